### hdl/cbss_pkg.sv
// ----------------------------------------------------------------------------
// cbss_pkg
// shared types and constants for the continuous batching slot scheduler
// ----------------------------------------------------------------------------
package cbss_pkg;

  localparam int unsigned IdW      = 16;
  localparam int unsigned StepW    = 16;
  localparam int unsigned TickW    = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgAw    = 2;
  localparam int unsigned CfgDw    = 32;
  localparam int unsigned ActW     = 4;
  localparam int unsigned QentW    = IdW + StepW + TickW;
  localparam int unsigned SlotEntW = IdW + StepW + 2 * TickW;

  localparam logic [KindW-1:0] KIND_DONE   = 2'd0;
  localparam logic [KindW-1:0] KIND_ACCEPT = 2'd1;
  localparam logic [KindW-1:0] KIND_DROP   = 2'd2;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [CfgAw-1:0] REG_ACTIVE_SLOTS = 2'd0;

  typedef struct packed {
    logic            func;
    logic [IdW-1:0]  req_id;
    logic [StepW-1:0] step_count;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   done_id;
    logic [TickW-1:0] admit_tick;
    logic [TickW-1:0] finish_tick;
    logic [TickW-1:0] queued_ticks;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_QREAD,
    ST_SLOT,
    ST_FIN
  } state_e;

endpackage

### hdl/cbss_if.sv
// ----------------------------------------------------------------------------
// cbss_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface cbss_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/continuous_batch_slot_scheduler.sv
// ----------------------------------------------------------------------------
// continuous_batch_slot_scheduler
// continuous batching scheduler: wait queue plus slot table walked per tick
// ----------------------------------------------------------------------------
// arrival: ST_ARRIVE queues it (if not full) and registers the result; the
//   next item is taken once that result has left
// tick: ST_QREAD (table read), ST_SLOT (update) per slot, then ST_FIN; a further
//   completion waits while the previous result is still held on the output
// rst_ni clears tick, queue pointers, busy flags and active_slots (to 8);
// slot and queue memories are not cleared
module continuous_batch_slot_scheduler #(
  parameter int unsigned SLOT_COUNT  = 8,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  cbss_if.sink                      in_if,
  cbss_if.source                    out_if,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cbss_pkg::CfgAw-1:0] paddr,
  input  logic [cbss_pkg::CfgDw-1:0] pwdata,
  output logic [cbss_pkg::CfgDw-1:0] prdata,
  output logic                      pready
);
  localparam int unsigned SlotAw = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned LimW   = $clog2(SLOT_COUNT + 1);

  cbss_pkg::state_e state_q, state_d;

  logic [cbss_pkg::ActW-1:0]  act_q;
  logic [cbss_pkg::TickW-1:0] tick_q, tick_d;
  logic [SlotAw-1:0]          idx_q, idx_d;
  logic [LimW-1:0]            lim;
  logic [cbss_pkg::IdW-1:0]   id_q;
  logic [cbss_pkg::StepW-1:0] step_q;
  logic                       drop_q;
  cbss_pkg::out_item_t        res_q, res_d;
  cbss_pkg::out_item_t        pend_q, pend_d;  // completion held back for last
  logic                       pend_v_q, pend_v_d;
  logic                       ov_q, ov_d;

  logic                          q_push, q_pop, q_rd, q_full, q_empty;
  logic [cbss_pkg::QentW-1:0]    q_rdata, q_wdata;
  logic                          s_wr, s_wbusy, s_rbusy;
  logic [cbss_pkg::SlotEntW-1:0] s_wdata, s_rdata;
  logic                          in_acc, out_acc;
  logic                          admit, busy_now, fin, last_slot, hold;
  logic [15:0]                   rem_now, id_now;
  logic [31:0]                   start_now, arr_now;

  // queue entry: id low, step count (zero stored as one), arrival tick high
  assign q_wdata = {tick_q, (step_q == '0) ? cbss_pkg::StepW'(1) : step_q, id_q};

  cbss_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push),
    .push_data_i(q_wdata),
    .pop_i(q_pop), .rd_req_i(q_rd),
    .rd_data_o(q_rdata), .full_o(q_full), .empty_o(q_empty)
  );

  // slot table, read and written at the slot being walked
  cbss_slots #(.Slots(SLOT_COUNT)) u_slots (
    .clk_i, .rst_ni,
    .rd_idx_i(idx_q), .rd_busy_o(s_rbusy), .rd_data_o(s_rdata),
    .wr_i(s_wr), .wr_idx_i(idx_q), .wr_busy_i(s_wbusy), .wr_data_i(s_wdata)
  );

  // effective active slot count, clamped to 1..SLOT_COUNT
  always_comb begin
    if (act_q == '0) begin
      lim = LimW'(1);
    end else if ({28'd0, act_q} > 32'(SLOT_COUNT)) begin
      lim = LimW'(SLOT_COUNT);
    end else begin
      lim = LimW'(act_q);
    end
  end

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr == cbss_pkg::REG_ACTIVE_SLOTS) ? {28'd0, act_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 4'd8;
    end else if (psel && penable && pwrite && paddr == cbss_pkg::REG_ACTIVE_SLOTS) begin
      act_q <= pwdata[cbss_pkg::ActW-1:0];
    end
  end

  // handshakes: a new item only once the previous result has left
  assign in_if.ready  = (state_q == cbss_pkg::ST_IDLE) && !ov_q;
  assign out_if.valid = ov_q;
  assign out_if.data  = res_q;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = ov_q && out_if.ready;

  // slot walk: ST_QREAD reads slot idx and the queue head;
  // ST_SLOT admits, steps and retires it. each completion waits in pend
  // until the next one (or the end of the walk) shows whether it is last
  always_comb begin
    admit     = !s_rbusy && !q_empty && (LimW'(idx_q) < lim);
    busy_now  = s_rbusy || admit;
    id_now    = admit ? q_rdata[15:0]  : s_rdata[15:0];
    rem_now   = admit ? q_rdata[31:16] : s_rdata[31:16];
    start_now = admit ? tick_q         : s_rdata[63:32];
    arr_now   = admit ? q_rdata[63:32] : s_rdata[95:64];
    fin       = busy_now && (rem_now <= 16'd1);
    last_slot = (idx_q == SlotAw'(SLOT_COUNT - 1));
    // pend has to move out but the output is still occupied; the slot
    // read is repeated each cycle, so the entry simply waits
    hold      = fin && pend_v_q && ov_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cbss_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_if.data.func == cbss_pkg::FUNC_TICK) ? cbss_pkg::ST_QREAD
                                                              : cbss_pkg::ST_ARRIVE;
        end
      end
      cbss_pkg::ST_ARRIVE: state_d = cbss_pkg::ST_IDLE;
      cbss_pkg::ST_QREAD:  state_d = cbss_pkg::ST_SLOT;
      cbss_pkg::ST_SLOT: begin
        if (!hold) begin
          state_d = last_slot ? cbss_pkg::ST_FIN : cbss_pkg::ST_QREAD;
        end
      end
      cbss_pkg::ST_FIN: begin
        if (!pend_v_q || !ov_q) begin
          state_d = cbss_pkg::ST_IDLE;
        end
      end
      default: state_d = cbss_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_push   = 1'b0;
    q_pop    = 1'b0;
    q_rd     = 1'b0;
    s_wr     = 1'b0;
    s_wbusy  = busy_now && !fin;
    s_wdata  = {arr_now, start_now, rem_now - 16'd1, id_now};
    idx_d    = idx_q;
    tick_d   = tick_q;
    res_d    = res_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    ov_d     = ov_q && !out_acc;
    case (state_q)
      cbss_pkg::ST_IDLE: begin
        idx_d    = '0;
        pend_v_d = 1'b0;
      end
      cbss_pkg::ST_ARRIVE: begin
        q_push = !drop_q;
        res_d  = '{kind: drop_q ? cbss_pkg::KIND_DROP : cbss_pkg::KIND_ACCEPT,
                   done_id: id_q, admit_tick: '0, finish_tick: '0,
                   queued_ticks: '0, last: 1'b1};
        ov_d   = 1'b1;
      end
      cbss_pkg::ST_QREAD: begin
        q_rd = 1'b1;
      end
      cbss_pkg::ST_SLOT: begin
        if (!hold) begin
          q_pop = admit;
          s_wr  = 1'b1;
          if (fin) begin
            // an older completion exists, so it is not the last one
            if (pend_v_q) begin
              res_d = pend_q;
              ov_d  = 1'b1;
            end
            pend_v_d = 1'b1;
            pend_d   = '{kind: cbss_pkg::KIND_DONE, done_id: id_now,
                         admit_tick: start_now, finish_tick: tick_q,
                         queued_ticks: start_now - arr_now, last: 1'b0};
          end
          if (!last_slot) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      cbss_pkg::ST_FIN: begin
        // walk done: the held completion goes out marked last
        if (!pend_v_q || !ov_q) begin
          tick_d = tick_q + 1'b1;
          if (pend_v_q) begin
            res_d      = pend_q;
            res_d.last = 1'b1;
            ov_d       = 1'b1;
            pend_v_d   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cbss_pkg::ST_IDLE;
      tick_q   <= '0;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      tick_q   <= tick_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    pend_q <= pend_d;
    if (in_acc) begin
      id_q   <= in_if.data.req_id;
      step_q <= in_if.data.step_count;
      drop_q <= q_full;
    end
  end
endmodule

### hdl/cbss_queue.sv
// ----------------------------------------------------------------------------
// cbss_queue
// wait queue: synchronous memory with head/tail/count pointers
// ----------------------------------------------------------------------------
module cbss_queue #(
  parameter int unsigned Depth = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [cbss_pkg::QentW-1:0]    push_data_i,
  input  logic                          pop_i,
  input  logic                          rd_req_i,
  output logic [cbss_pkg::QentW-1:0]    rd_data_o,
  output logic                          full_o,
  output logic                          empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [cbss_pkg::QentW-1:0] mem [Depth];
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    if (p == AW'(Depth - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d = nxt(tail_q);
    end
    if (pop_i) begin
      head_d = nxt(head_q);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= push_data_i;
    end
    if (rd_req_i) begin
      rd_data_o <= mem[head_q];
    end
  end

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
endmodule

### hdl/cbss_slots.sv
// ----------------------------------------------------------------------------
// cbss_slots
// slot table memory with busy flags, one entry read and written per cycle
// ----------------------------------------------------------------------------
module cbss_slots #(
  parameter int unsigned Slots = 8
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [((Slots > 1) ? $clog2(Slots) : 1)-1:0] rd_idx_i,
  output logic                                       rd_busy_o,
  output logic [cbss_pkg::SlotEntW-1:0]              rd_data_o,
  input  logic                                       wr_i,
  input  logic [((Slots > 1) ? $clog2(Slots) : 1)-1:0] wr_idx_i,
  input  logic                                       wr_busy_i,
  input  logic [cbss_pkg::SlotEntW-1:0]              wr_data_i
);
  // entry: id[15:0], remaining[31:16], start[63:32], arrival[95:64]
  logic [cbss_pkg::SlotEntW-1:0] mem [Slots];
  logic [Slots-1:0]              busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      rd_busy_o <= 1'b0;
    end else begin
      if (wr_i) begin
        busy_q[wr_idx_i] <= wr_busy_i;
      end
      rd_busy_o <= busy_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_idx_i];
  end
endmodule

### bench/cbss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbss_checker
// watches the request and result channels and the register port, keeps its
// own copy of the queue and slot table and compares every result in order
// ----------------------------------------------------------------------------
module cbss_checker #(
  parameter int unsigned SLOT_COUNT  = 8,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  cbss_pkg::in_item_t          in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  cbss_pkg::out_item_t         out_data_i,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbss_pkg::CfgAw-1:0]  paddr,
  input  logic [cbss_pkg::CfgDw-1:0]  pwdata,
  input  logic                        pready,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);

  typedef struct {
    logic [cbss_pkg::IdW-1:0]   id;
    logic [cbss_pkg::StepW-1:0] steps;
    logic [cbss_pkg::TickW-1:0] arrival;
  } waiting_req_t;

  logic [cbss_pkg::TickW-1:0] tick_now;
  logic [cbss_pkg::ActW-1:0]  slots_cfg;
  logic                       busy       [SLOT_COUNT];
  logic [cbss_pkg::IdW-1:0]   slot_id    [SLOT_COUNT];
  logic [cbss_pkg::StepW-1:0] slot_left  [SLOT_COUNT];
  logic [cbss_pkg::TickW-1:0] slot_begin [SLOT_COUNT];
  logic [cbss_pkg::TickW-1:0] slot_arr   [SLOT_COUNT];
  waiting_req_t               waiting_q  [$];
  cbss_pkg::out_item_t        expected_q [$];

  assign pending_o = expected_q.size();

  function automatic cbss_pkg::out_item_t mk_result(
      logic [cbss_pkg::KindW-1:0] k, logic [cbss_pkg::IdW-1:0] id,
      logic [cbss_pkg::TickW-1:0] st, logic [cbss_pkg::TickW-1:0] ct,
      logic [cbss_pkg::TickW-1:0] wt, logic lst);
    cbss_pkg::out_item_t r;
    r.kind = k; r.done_id = id; r.admit_tick = st;
    r.finish_tick = ct; r.queued_ticks = wt; r.last = lst;
    return r;
  endfunction

  function automatic void add_expected(cbss_pkg::out_item_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void schedule_item(cbss_pkg::in_item_t it);
    waiting_req_t w;
    int unsigned  lim;
    int           first;
    if (it.func == cbss_pkg::FUNC_ARRIVE) begin
      if (waiting_q.size() >= QUEUE_DEPTH) begin
        add_expected(mk_result(cbss_pkg::KIND_DROP, it.req_id, '0, '0, '0, 1'b1));
      end else begin
        w.id = it.req_id;
        w.steps = (it.step_count == '0) ? cbss_pkg::StepW'(1) : it.step_count;
        w.arrival = tick_now;
        waiting_q.insert(waiting_q.size(), w);
        add_expected(mk_result(cbss_pkg::KIND_ACCEPT, it.req_id, '0, '0, '0, 1'b1));
      end
      return;
    end
    lim = (slots_cfg == 0) ? 1 : (slots_cfg > SLOT_COUNT) ? SLOT_COUNT : slots_cfg;
    // admission in slot order
    for (int s = 0; s < lim; s++) begin
      if (!busy[s] && waiting_q.size() > 0) begin
        w = waiting_q.pop_front();
        busy[s] = 1'b1;
        slot_id[s] = w.id;
        slot_left[s] = w.steps;
        slot_begin[s] = tick_now;
        slot_arr[s] = w.arrival;
      end
    end
    // decode step and retirement
    first = expected_q.size();
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (busy[s]) begin
        if (slot_left[s] > 1) begin
          slot_left[s]--;
        end else begin
          busy[s] = 1'b0;
          add_expected(mk_result(cbss_pkg::KIND_DONE, slot_id[s], slot_begin[s],
                                 tick_now, slot_begin[s] - slot_arr[s], 1'b0));
        end
      end
    end
    if (expected_q.size() > first) expected_q[expected_q.size()-1].last = 1'b1;
    tick_now = tick_now + 1;
  endfunction

  function automatic void check_field(string name, logic [cbss_pkg::TickW-1:0] exp_v,
                                      logic [cbss_pkg::TickW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cbss_pkg::out_item_t e;
    if (!rst_ni) begin
      tick_now = '0;
      slots_cfg = cbss_pkg::ActW'(8);
      foreach (busy[s]) busy[s] = 1'b0;
      waiting_q.delete();
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == cbss_pkg::REG_ACTIVE_SLOTS)
        slots_cfg = pwdata[cbss_pkg::ActW-1:0];
      if (in_valid_i && in_ready_i) schedule_item(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: id %0h", out_data_i.done_id);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          check_field("kind", e.kind, out_data_i.kind);
          check_field("done_id", e.done_id, out_data_i.done_id);
          check_field("admit_tick", e.admit_tick, out_data_i.admit_tick);
          check_field("finish_tick", e.finish_tick, out_data_i.finish_tick);
          check_field("queued_ticks", e.queued_ticks, out_data_i.queued_ticks);
          check_field("last", e.last, out_data_i.last);
        end
      end
    end
  end

endmodule

### bench/continuous_batch_slot_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// continuous_batch_slot_scheduler_tb
// drives arrivals and ticks through several slot settings, including a
// queue overflow, with random gaps and stalls; the checker judges results
// ----------------------------------------------------------------------------
module continuous_batch_slot_scheduler_tb;

  localparam int unsigned NumSlots  = 8;
  localparam int unsigned QueueSize = 64;
  localparam int unsigned SettleCyc = 40;   // long enough for a tick to walk all slots

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [cbss_pkg::CfgAw-1:0] paddr = '0;
  logic [cbss_pkg::CfgDw-1:0] pwdata = '0;
  logic [cbss_pkg::CfgDw-1:0] prdata;
  logic                       pready;
  logic                       gaps_on = 1'b1;     // sender may idle
  logic                       stalls_on = 1'b1;   // receiver may stall
  int unsigned                fail_count;
  int unsigned                pending;

  cbss_if #(.T(cbss_pkg::in_item_t))  in_ch ();
  cbss_if #(.T(cbss_pkg::out_item_t)) out_ch ();

  always #10 clk_i = ~clk_i;

  continuous_batch_slot_scheduler #(
    .SLOT_COUNT (NumSlots),
    .QUEUE_DEPTH(QueueSize)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  cbss_checker #(
    .SLOT_COUNT (NumSlots),
    .QUEUE_DEPTH(QueueSize)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // receiver stalls about a third of the cycles when allowed
  initial out_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    out_ch.ready = stalls_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
  end

  // one item through the request channel, with an optional random gap first
  task automatic send_item(logic fn, logic [cbss_pkg::IdW-1:0] id,
                           logic [cbss_pkg::StepW-1:0] steps);
    cbss_pkg::in_item_t it;
    it.func = fn; it.req_id = id; it.step_count = steps;
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic arrive(logic [cbss_pkg::IdW-1:0] id, logic [cbss_pkg::StepW-1:0] steps);
    send_item(cbss_pkg::FUNC_ARRIVE, id, steps);
  endtask

  task automatic tick(int unsigned n);
    repeat (n) send_item(cbss_pkg::FUNC_TICK, 16'($urandom), 16'($urandom));
  endtask

  // register write only once every outstanding result is back and a tick
  // that gives no result has had time to finish its slot walk
  task automatic set_slots(logic [cbss_pkg::CfgDw-1:0] v);
    wait (pending == 0);
    repeat (SettleCyc) @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = cbss_pkg::REG_ACTIVE_SLOTS; pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // random mix with mostly short requests so slots turn over often
  task automatic random_phase(int unsigned n);
    logic [cbss_pkg::StepW-1:0] st;
    repeat (n) begin
      st = ($urandom_range(0, 99) < 80) ? cbss_pkg::StepW'($urandom_range(0, 5))
                                        : cbss_pkg::StepW'($urandom_range(0, 20));
      if ($urandom_range(0, 99) < 55) arrive(16'($urandom), st);
      else tick(1);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: id and step extremes, zero steps, completions in one tick
    arrive(16'h0000, 16'h0000);
    arrive(16'hffff, 16'h0001);
    arrive(16'h1234, 16'h0002);
    arrive(16'ha5a5, 16'h0003);
    tick(1);                    // tick with two completions at once
    tick(3);                    // ends with a tick with no result
    set_slots(1);               // single slot makes requests wait
    arrive(16'h0101, 16'h0002);
    arrive(16'h0202, 16'h0001);
    arrive(16'h0303, 16'h0000);
    tick(5);

    // lower the slot count while slots are still busy
    set_slots(8);
    for (int i = 0; i < 8; i++) arrive(16'(16'h0400 + i), 16'(3 + i));
    tick(2);
    set_slots(2);
    tick(6);

    // overflow: fill the queue without ticks, then drops with wide fields
    set_slots(0);
    for (int i = 0; i < QueueSize + 2; i++) begin
      if (i < QueueSize) arrive(16'($urandom), 16'($urandom_range(0, 2)));
      else arrive(16'($urandom), (i == QueueSize) ? 16'hffff : 16'($urandom));
    end
    set_slots(8);
    tick(6);

    // random phases over settings, one stretch with neither gaps nor stalls
    set_slots(15);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    random_phase(12);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    set_slots(3);
    random_phase(4);
    set_slots(8);
    random_phase(4);
    tick(4);

    wait (pending == 0);
    repeat (SettleCyc) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
